// ===== rtl/core/gtrs_pkg.sv =====
// shared types, codes and reset values for the gpu thermal read supervisor
package gtrs_pkg;

	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;

	localparam logic [1:0] RegErrorLimit    = 2'd0;
	localparam logic [1:0] RegShutdownLimit = 2'd1;
	localparam logic [1:0] RegDecayFloor    = 2'd2;
	localparam logic [1:0] RegDecayCeiling  = 2'd3;

	localparam logic [5:0] ErrorLimitReset    = 6'd3;
	localparam logic [5:0] ShutdownLimitReset = 6'd34;
	localparam logic [6:0] DecayFloorReset    = 7'd32;
	localparam logic [6:0] DecayCeilingReset  = 7'd100;

	localparam logic [5:0] CountMax = 6'h3F;

	// reciprocal of three, exact for sums up to 383
	localparam logic [7:0] RecipThree = 8'd171;
	localparam int unsigned RecipShift = 9;

	typedef enum logic [1:0] {
		CAUSE_NONE = 2'd0,
		CAUSE_BUS  = 2'd1,
		CAUSE_ZERO = 2'd2
	} cause_t;

	typedef struct packed {
		logic [5:0] error_limit;
		logic [5:0] shutdown_limit;
		logic [6:0] decay_floor;
		logic [6:0] decay_ceiling;
	} cfg_t;

	typedef struct packed {
		logic       system_active;
		logic       gpu_present;
		logic       os_acpi_mode;
		logic       init_delay_active;
		logic       debug_hold;
		logic       bus_ok;
		logic [7:0] sensor_byte;
	} item_t;

	typedef struct packed {
		logic [6:0] temperature;
		logic [6:0] average_temp;
		logic       error_flag;
		logic       init_done;
		cause_t     shutdown_cause;
		logic       bus_reset;
	} res_t;

endpackage

// ===== rtl/core/gtrs_cfg.sv =====
// apb configuration registers
module gtrs_cfg import gtrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output cfg_t                 cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_limit    <= ErrorLimitReset;
			cfg_q.shutdown_limit <= ShutdownLimitReset;
			cfg_q.decay_floor    <= DecayFloorReset;
			cfg_q.decay_ceiling  <= DecayCeilingReset;
		end else if (wr_en) begin
			case (reg_idx)
				RegErrorLimit:    cfg_q.error_limit    <= pwdata[5:0];
				RegShutdownLimit: cfg_q.shutdown_limit <= pwdata[5:0];
				RegDecayFloor:    cfg_q.decay_floor    <= pwdata[6:0];
				RegDecayCeiling:  cfg_q.decay_ceiling  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegErrorLimit:    prdata = {{(DataWidth-6){1'b0}}, cfg_q.error_limit};
			RegShutdownLimit: prdata = {{(DataWidth-6){1'b0}}, cfg_q.shutdown_limit};
			RegDecayFloor:    prdata = {{(DataWidth-7){1'b0}}, cfg_q.decay_floor};
			RegDecayCeiling:  prdata = {{(DataWidth-7){1'b0}}, cfg_q.decay_ceiling};
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/gtrs_core.sv =====
// supervisor state and per-tick update logic
module gtrs_core import gtrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	logic       init_q, fault_q;
	logic [5:0] count_q;
	logic [6:0] temp_q, prev1_q, prev2_q, mean_q;

	logic       init_d, fault_d;
	logic [5:0] count_d, count_inc;
	logic [6:0] temp_d, prev1_d, prev2_d, mean_d, decayed;
	logic       do_push, active, above_floor;
	cause_t     cause;
	logic       bus_rst;
	logic [8:0] sum;
	logic [16:0] prod;

	assign active      = item.system_active && item.gpu_present && item.os_acpi_mode;
	assign above_floor = temp_q > cfg.decay_floor;
	assign count_inc   = (count_q == CountMax) ? CountMax : count_q + 6'd1;

	always_comb begin
		if (!above_floor) begin
			decayed = temp_q;
		end else if (temp_q > cfg.decay_ceiling) begin
			decayed = cfg.decay_ceiling;
		end else begin
			decayed = temp_q - 7'd1;
		end
	end

	always_comb begin
		init_d  = init_q;
		fault_d = fault_q;
		count_d = count_q;
		temp_d  = temp_q;
		do_push = 1'b0;
		cause   = CAUSE_NONE;
		bus_rst = 1'b0;
		if (!init_q && (!active || item.init_delay_active)) begin
			fault_d = 1'b0;
			count_d = '0;
			temp_d  = decayed;
			do_push = 1'b1;
		end else if (init_q && !active) begin
			fault_d = 1'b0;
			init_d  = 1'b0;
			count_d = '0;
			if (above_floor) begin
				temp_d  = decayed;
				do_push = !item.debug_hold;
			end
		end else if (!item.bus_ok || (init_q && item.sensor_byte == 8'd0)) begin
			init_d  = 1'b0;
			bus_rst = !item.bus_ok;
			count_d = count_inc;
			if (!fault_q) begin
				if (count_inc > cfg.error_limit) begin
					fault_d = 1'b1;
				end
			end else if (count_inc > cfg.shutdown_limit) begin
				count_d = '0;
				cause   = item.bus_ok ? CAUSE_ZERO : CAUSE_BUS;
			end
		end else if (!init_q) begin
			init_d  = 1'b1;
			fault_d = 1'b0;
		end else begin
			temp_d  = item.sensor_byte[7:1];
			count_d = '0;
			fault_d = 1'b0;
			do_push = !item.debug_hold;
		end
	end

	assign sum  = {2'b00, temp_d} + {2'b00, prev1_q} + {2'b00, prev2_q};
	assign prod = {8'd0, sum} * {9'd0, RecipThree};

	always_comb begin
		if (do_push) begin
			prev2_d = prev1_q;
			prev1_d = temp_d;
			mean_d  = prod[RecipShift +: 7];
		end else begin
			prev2_d = prev2_q;
			prev1_d = prev1_q;
			mean_d  = mean_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= 1'b0;
			fault_q <= 1'b0;
			count_q <= '0;
			temp_q  <= '0;
			prev1_q <= '0;
			prev2_q <= '0;
			mean_q  <= '0;
		end else if (en) begin
			init_q  <= init_d;
			fault_q <= fault_d;
			count_q <= count_d;
			temp_q  <= temp_d;
			prev1_q <= prev1_d;
			prev2_q <= prev2_d;
			mean_q  <= mean_d;
		end
	end

	assign res.temperature    = temp_d;
	assign res.average_temp   = mean_d;
	assign res.error_flag     = fault_d;
	assign res.init_done      = init_d;
	assign res.shutdown_cause = cause;
	assign res.bus_reset      = bus_rst;

endmodule

// ===== rtl/core/gpu_thermal_read_supervisor_top.sv =====
// top level of the gpu thermal read supervisor
//
// one input transfer per sensor tick carries the platform conditions, the bus
// status of that tick and the returned sensor byte; one result transfer per
// tick returns temperature, three-sample average, error and init flags, the
// shutdown cause and the bus reset request.
// both channels are valid/ready. an accepted tick is held in an input
// register, the supervisor state is updated from it and the result lands in
// an output register: the result is offered once the tick has moved from the
// input register into the output register, and one tick is taken every cycle
// while the receiver keeps taking results.
// while the result waits for the receiver the input register may still fill;
// in_ready drops only when both registers are occupied and the result is not
// taken.
// the apb port sets error_limit, shutdown_limit, decay_floor and
// decay_ceiling at byte addresses 0, 4, 8 and 12; pready is always high.
// reset clears the supervisor state and both valid flags and loads the
// register defaults 3, 34, 32 and 100.
module gpu_thermal_read_supervisor_top import gtrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 system_active,
	input  logic                 gpu_present,
	input  logic                 os_acpi_mode,
	input  logic                 init_delay_active,
	input  logic                 debug_hold,
	input  logic                 bus_ok,
	input  logic [7:0]           sensor_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [6:0]           temperature,
	output logic [6:0]           average_temp,
	output logic                 error_flag,
	output logic                 init_done,
	output logic [1:0]           shutdown_cause,
	output logic                 bus_reset,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_next, res_q;
	logic  out_valid_q;
	logic  advance;

	assign pready   = 1'b1;
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	gtrs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	gtrs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.system_active     <= system_active;
			item_s1.gpu_present       <= gpu_present;
			item_s1.os_acpi_mode      <= os_acpi_mode;
			item_s1.init_delay_active <= init_delay_active;
			item_s1.debug_hold        <= debug_hold;
			item_s1.bus_ok            <= bus_ok;
			item_s1.sensor_byte       <= sensor_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign temperature    = res_q.temperature;
	assign average_temp   = res_q.average_temp;
	assign error_flag     = res_q.error_flag;
	assign init_done      = res_q.init_done;
	assign shutdown_cause = res_q.shutdown_cause;
	assign bus_reset      = res_q.bus_reset;

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the gpu thermal read supervisor top level
`timescale 1ns / 100ps

module tb;
	import gtrs_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int PhaseTicks = 345;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic system_active = 1'b0;
	logic gpu_present = 1'b0;
	logic os_acpi_mode = 1'b0;
	logic init_delay_active = 1'b0;
	logic debug_hold = 1'b0;
	logic bus_ok = 1'b0;
	logic [7:0] sensor_byte = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [6:0] temperature;
	logic [6:0] average_temp;
	logic error_flag;
	logic init_done;
	logic [1:0] shutdown_cause;
	logic bus_reset;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrWidth-1:0] paddr = '0;
	logic [DataWidth-1:0] pwdata = '0;
	logic [DataWidth-1:0] prdata;
	logic pready;

	gpu_thermal_read_supervisor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.system_active(system_active),
		.gpu_present(gpu_present),
		.os_acpi_mode(os_acpi_mode),
		.init_delay_active(init_delay_active),
		.debug_hold(debug_hold),
		.bus_ok(bus_ok),
		.sensor_byte(sensor_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temperature(temperature),
		.average_temp(average_temp),
		.error_flag(error_flag),
		.init_done(init_done),
		.shutdown_cause(shutdown_cause),
		.bus_reset(bus_reset),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// supervisor state as the block should hold it
	cfg_t cfg;
	logic st_init;
	logic [5:0] st_fails;
	logic st_fault;
	logic [6:0] st_temp, st_hist1, st_hist2, st_avg;

	item_t pending_ticks[$];
	res_t due_readings[$];
	int ticks_queued = 0;
	int results_seen = 0;
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;
	bit in_xfer = 1'b0;

	function automatic void push_history();
		logic [8:0] sum;
		sum = {2'b00, st_temp} + {2'b00, st_hist1} + {2'b00, st_hist2};
		st_hist2 = st_hist1;
		st_hist1 = st_temp;
		st_avg = 7'(sum / 9'd3);
	endfunction

	function automatic void decay_temp();
		if (st_temp > cfg.decay_floor) begin
			if (st_temp > cfg.decay_ceiling)
				st_temp = cfg.decay_ceiling;
			else
				st_temp = st_temp - 7'd1;
		end
	endfunction

	function automatic cause_t count_failure(cause_t why);
		if (st_fails != CountMax)
			st_fails = st_fails + 6'd1;
		if (!st_fault) begin
			if (st_fails > cfg.error_limit)
				st_fault = 1'b1;
		end else if (st_fails > cfg.shutdown_limit) begin
			st_fails = '0;
			return why;
		end
		return CAUSE_NONE;
	endfunction

	function automatic res_t predict_tick(item_t it);
		logic active;
		cause_t cause;
		logic brst;
		res_t r;
		active = it.system_active & it.gpu_present & it.os_acpi_mode;
		cause = CAUSE_NONE;
		brst = 1'b0;
		if (!st_init) begin
			if (!active || it.init_delay_active) begin
				st_fault = 1'b0;
				st_fails = '0;
				decay_temp();
				push_history();
			end else if (!it.bus_ok) begin
				cause = count_failure(CAUSE_BUS);
				brst = 1'b1;
			end else begin
				st_init = 1'b1;
				st_fault = 1'b0;
			end
		end else begin
			if (!active) begin
				st_fault = 1'b0;
				st_init = 1'b0;
				st_fails = '0;
				if (st_temp > cfg.decay_floor) begin
					decay_temp();
					if (!it.debug_hold)
						push_history();
				end
			end else if (!it.bus_ok) begin
				st_init = 1'b0;
				cause = count_failure(CAUSE_BUS);
				brst = 1'b1;
			end else if (it.sensor_byte == 8'd0) begin
				st_init = 1'b0;
				cause = count_failure(CAUSE_ZERO);
			end else begin
				st_temp = it.sensor_byte[7:1];
				st_fails = '0;
				st_fault = 1'b0;
				if (!it.debug_hold)
					push_history();
			end
		end
		r.temperature = st_temp;
		r.average_temp = st_avg;
		r.error_flag = st_fault;
		r.init_done = st_init;
		r.shutdown_cause = cause;
		r.bus_reset = brst;
		return r;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// sender
	int send_gap = 0;
	always @(negedge clk) begin
		item_t nxt;
		if (arst_n && (!in_valid || in_xfer)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_ticks.size() > 0) begin
				nxt = pending_ticks.pop_front();
				system_active <= nxt.system_active;
				gpu_present <= nxt.gpu_present;
				os_acpi_mode <= nxt.os_acpi_mode;
				init_delay_active <= nxt.init_delay_active;
				debug_hold <= nxt.debug_hold;
				bus_ok <= nxt.bus_ok;
				sensor_byte <= nxt.sensor_byte;
				in_valid <= 1'b1;
				if (idle_pct > 0 && $urandom_range(99) < idle_pct)
					send_gap = $urandom_range(1, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with long hold-offs counted here
	int stall_left = 0;
	int hold_left = 0;
	int hold_mark = 200;
	always @(negedge clk) begin
		if (hold_mark < 1200 && results_seen >= hold_mark) begin
			hold_left = 60;
			hold_mark += 800;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			stall_left = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: check the result transfer, then predict the input transfer
	always @(posedge clk) begin
		res_t got, want;
		item_t seen;
		in_xfer = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got.temperature = temperature;
			got.average_temp = average_temp;
			got.error_flag = error_flag;
			got.init_done = init_done;
			got.shutdown_cause = cause_t'(shutdown_cause);
			got.bus_reset = bus_reset;
			if (due_readings.size() == 0) begin
				flag_mismatch("result with nothing expected", 0, 0);
			end else begin
				want = due_readings.pop_front();
				if (got.temperature !== want.temperature)
					flag_mismatch("temperature", got.temperature, want.temperature);
				if (got.average_temp !== want.average_temp)
					flag_mismatch("average_temp", got.average_temp, want.average_temp);
				if (got.error_flag !== want.error_flag)
					flag_mismatch("error_flag", got.error_flag, want.error_flag);
				if (got.init_done !== want.init_done)
					flag_mismatch("init_done", got.init_done, want.init_done);
				if (got.shutdown_cause !== want.shutdown_cause)
					flag_mismatch("shutdown_cause", got.shutdown_cause, want.shutdown_cause);
				if (got.bus_reset !== want.bus_reset)
					flag_mismatch("bus_reset", got.bus_reset, want.bus_reset);
			end
		end
		if (in_xfer) begin
			seen.system_active = system_active;
			seen.gpu_present = gpu_present;
			seen.os_acpi_mode = os_acpi_mode;
			seen.init_delay_active = init_delay_active;
			seen.debug_hold = debug_hold;
			seen.bus_ok = bus_ok;
			seen.sensor_byte = sensor_byte;
			due_readings.push_back(predict_tick(seen));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic void add_tick(logic [2:0] up, logic dly, logic hold, logic ok,
			logic [7:0] sensor);
		item_t it;
		it.system_active = up[2];
		it.gpu_present = up[1];
		it.os_acpi_mode = up[0];
		it.init_delay_active = dly;
		it.debug_hold = hold;
		it.bus_ok = ok;
		it.sensor_byte = sensor;
		pending_ticks.push_back(it);
		ticks_queued++;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegErrorLimit: cfg.error_limit = value[5:0];
			RegShutdownLimit: cfg.shutdown_limit = value[5:0];
			RegDecayFloor: cfg.decay_floor = value[6:0];
			RegDecayCeiling: cfg.decay_ceiling = value[6:0];
			default: ;
		endcase
	endtask

	// upper data bits are junk and must be dropped by the register
	task automatic set_limits(logic [5:0] err_lim, logic [5:0] shut_lim, logic [6:0] floor_v,
			logic [6:0] ceil_v);
		write_reg(RegErrorLimit, {26'($urandom_range(0, 32'h3ff_ffff)), err_lim});
		write_reg(RegShutdownLimit, {26'($urandom_range(0, 32'h3ff_ffff)), shut_lim});
		write_reg(RegDecayFloor, {25'($urandom_range(0, 32'h1ff_ffff)), floor_v});
		write_reg(RegDecayCeiling, {25'($urandom_range(0, 32'h1ff_ffff)), ceil_v});
	endtask

	task automatic drain();
		while (pending_ticks.size() != 0 || in_valid || due_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly well-formed sequences: failure runs long enough to reach shutdown,
	// init then good reads, zero readings, power-down stretches, plus noise
	task automatic queue_random_ticks(int n);
		int target, kind, len;
		logic [2:0] up;
		target = ticks_queued + n;
		while (ticks_queued < target) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				len = $urandom_range(1, 45);
				repeat (len)
					add_tick(3'b111, 1'b0, 1'($urandom), 1'b0, 8'($urandom));
			end else if (kind < 58) begin
				add_tick(3'b111, 1'b0, 1'($urandom), 1'b1, 8'($urandom));
				len = $urandom_range(1, 6);
				repeat (len)
					add_tick(3'b111, 1'($urandom), $urandom_range(3) == 0, 1'b1,
						8'($urandom_range(1, 255)));
			end else if (kind < 68) begin
				add_tick(3'b111, 1'b0, 1'($urandom), 1'b1, 8'($urandom));
				add_tick(3'b111, 1'($urandom), 1'($urandom), 1'b1, 8'd0);
			end else if (kind < 85) begin
				len = $urandom_range(1, 5);
				repeat (len) begin
					up = 3'($urandom);
					add_tick(up, (up == 3'b111) ? 1'b1 : 1'($urandom), 1'($urandom),
						1'($urandom), 8'($urandom));
				end
			end else begin
				add_tick(3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
					($urandom_range(7) == 0) ? 8'd0 : 8'($urandom));
			end
		end
	endtask

	initial begin
		cfg.error_limit = ErrorLimitReset;
		cfg.shutdown_limit = ShutdownLimitReset;
		cfg.decay_floor = DecayFloorReset;
		cfg.decay_ceiling = DecayCeilingReset;
		st_init = 1'b0;
		st_fails = '0;
		st_fault = 1'b0;
		st_temp = '0;
		st_hist1 = '0;
		st_hist2 = '0;
		st_avg = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part with reset limits
		idle_pct = 25;
		add_tick(3'b111, 1'b1, 1'b0, 1'b1, 8'h00);
		add_tick(3'b011, 1'b0, 1'b1, 1'b1, 8'hff);
		repeat (4)
			add_tick(3'b111, 1'b0, 1'b0, 1'b0, 8'h55);
		add_tick(3'b111, 1'b0, 1'b0, 1'b1, 8'h00);
		add_tick(3'b111, 1'b0, 1'b0, 1'b1, 8'hff);
		add_tick(3'b111, 1'b0, 1'b1, 1'b1, 8'hfe);
		add_tick(3'b110, 1'b0, 1'b0, 1'b1, 8'haa);
		add_tick(3'b101, 1'b1, 1'b0, 1'b0, 8'h00);
		add_tick(3'b111, 1'b0, 1'b0, 1'b1, 8'h01);
		add_tick(3'b111, 1'b1, 1'b0, 1'b1, 8'h81);
		add_tick(3'b101, 1'b0, 1'b1, 1'b1, 8'h81);
		add_tick(3'b111, 1'b0, 1'b0, 1'b1, 8'h00);
		add_tick(3'b111, 1'b0, 1'b0, 1'b1, 8'h00);
		add_tick(3'b111, 1'b0, 1'b0, 1'b1, 8'h00);
		add_tick(3'b111, 1'b0, 1'b0, 1'b0, 8'h7f);
		add_tick(3'b111, 1'b0, 1'b0, 1'b1, 8'h80);
		add_tick(3'b111, 1'b0, 1'b1, 1'b1, 8'h01);
		add_tick(3'b100, 1'b0, 1'b0, 1'b1, 8'h40);
		drain();

		set_limits(6'd0, 6'd0, 7'd0, 7'd127);
		idle_pct = 30;
		queue_random_ticks(PhaseTicks);
		drain();

		set_limits(6'd63, 6'd63, 7'd127, 7'd0);
		idle_pct = 15;
		queue_random_ticks(PhaseTicks);
		drain();

		set_limits(6'($urandom_range(0, 62)), 6'($urandom_range(0, 62)),
			7'($urandom), 7'($urandom));
		idle_pct = 40;
		queue_random_ticks(PhaseTicks);
		drain();

		set_limits(6'd62, 6'd5, 7'd40, 7'd90);
		idle_pct = 20;
		queue_random_ticks(PhaseTicks);
		drain();

		set_limits(ErrorLimitReset, ShutdownLimitReset, DecayFloorReset, DecayCeilingReset);
		idle_pct = 0;
		queue_random_ticks(PhaseTicks);
		drain();
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
